// ===== src/line_raster_stepper_macros.svh =====
// Assertion macros used by the line rasterizer stepper (lrs_stepper).
`ifndef LINE_RASTER_STEPPER_MACROS_SVH
`define LINE_RASTER_STEPPER_MACROS_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent.
`define LRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line raster check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define LRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line raster check failed");

`else

`define LRS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/lrs_pkg.sv =====
`timescale 1ns / 1ps

package lrs_pkg;

    localparam int CoordBits = 10;
    // Decision term range is about +/- 2^(CoordBits+1); keep one spare bit.
    localparam int ErrBits   = CoordBits + 3;
    localparam int ColorBits = 4;

    localparam logic [ColorBits-1:0] DrawColorReset = 4'hF;

    localparam logic KindLoad = 1'b0;
    localparam logic KindStep = 1'b1;

    typedef logic [CoordBits-1:0]     t_coord;
    typedef logic signed [ErrBits-1:0] t_err;
    typedef logic [ColorBits-1:0]     t_color;

    typedef struct packed {
        logic   kind;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_in_item;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        t_color pixel_color;
        logic   last_pixel;
    } t_out_item;

    // Line set up from a load item.
    typedef struct packed {
        t_coord cur_x;
        t_coord cur_y;
        t_err   decision_err;
        t_coord major_delta;
        t_coord minor_delta;
        logic   minor_decrement;
        logic   steep;
    } t_line;

endpackage

// ===== src/lrs_setup.sv =====
`timescale 1ns / 1ps

module lrs_setup (
    input  lrs_pkg::t_in_item i_item,
    output lrs_pkg::t_line    o_line
);
    import lrs_pkg::*;

    t_coord adx;
    t_coord ady;
    logic   steep;
    logic   swap;
    t_coord sx;
    t_coord sy;
    t_coord ex;
    t_coord ey;
    t_coord major;
    t_coord minor;

    always_comb begin
        adx = (i_item.x_start >= i_item.x_end) ? i_item.x_start - i_item.x_end
                                               : i_item.x_end - i_item.x_start;
        ady = (i_item.y_start >= i_item.y_end) ? i_item.y_start - i_item.y_end
                                               : i_item.y_end - i_item.y_start;
        // Slope of magnitude one stays on the x-major side.
        steep = ady > adx;
        // Start from the endpoint with the smaller major coordinate.
        swap  = steep ? (i_item.y_end < i_item.y_start) : (i_item.x_end < i_item.x_start);
        sx    = swap ? i_item.x_end   : i_item.x_start;
        sy    = swap ? i_item.y_end   : i_item.y_start;
        ex    = swap ? i_item.x_start : i_item.x_end;
        ey    = swap ? i_item.y_start : i_item.y_end;
        major = steep ? ady : adx;
        minor = steep ? adx : ady;

        o_line.cur_x           = sx;
        o_line.cur_y           = sy;
        o_line.major_delta     = major;
        o_line.minor_delta     = minor;
        o_line.steep           = steep;
        o_line.minor_decrement = steep ? (ex < sx) : (ey < sy);
        o_line.decision_err    = t_err'({2'b00, minor, 1'b0}) - t_err'({3'b000, major});
    end

endmodule

// ===== src/lrs_stepper.sv =====
`timescale 1ns / 1ps
`include "line_raster_stepper_macros.svh"

module lrs_stepper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_proc_valid,
    input  logic               i_kind,
    input  lrs_pkg::t_line     i_line,
    input  lrs_pkg::t_color    i_color,
    input  logic               i_out_stall,
    output logic               o_out_free,
    output logic               o_out_valid,
    output lrs_pkg::t_out_item o_out_item
);
    import lrs_pkg::*;

    t_coord    r_cur_x, n_cur_x;
    t_coord    r_cur_y, n_cur_y;
    t_err      r_err, n_err;
    t_coord    r_steps, n_steps;
    t_coord    r_major, n_major;
    t_coord    r_minor, n_minor;
    logic      r_minor_dec, n_minor_dec;
    logic      r_steep, n_steep;
    logic      r_active, n_active;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic   proc;
    logic   load;
    logic   emit;
    logic   last;
    logic   move_minor;
    t_coord minor_next;
    t_coord major_x_next;
    t_coord major_y_next;

    assign o_out_free = !r_out_valid || !i_out_stall;
    assign proc       = i_proc_valid && o_out_free;
    assign load       = proc && (i_kind == KindLoad);
    assign emit       = proc && (i_kind == KindStep) && r_active;
    assign last       = (r_steps == '0);

    always_comb begin
        move_minor   = !r_err[ErrBits-1];
        minor_next   = r_steep ? r_cur_x : r_cur_y;
        if (move_minor) begin
            minor_next = r_minor_dec ? minor_next - 1'b1 : minor_next + 1'b1;
        end
        major_x_next = r_cur_x + 1'b1;
        major_y_next = r_cur_y + 1'b1;

        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_err       = r_err;
        n_steps     = r_steps;
        n_major     = r_major;
        n_minor     = r_minor;
        n_minor_dec = r_minor_dec;
        n_steep     = r_steep;
        n_active    = r_active;

        if (load) begin
            // Drop any line in progress.
            n_cur_x     = i_line.cur_x;
            n_cur_y     = i_line.cur_y;
            n_err       = i_line.decision_err;
            n_steps     = i_line.major_delta;
            n_major     = i_line.major_delta;
            n_minor     = i_line.minor_delta;
            n_minor_dec = i_line.minor_decrement;
            n_steep     = i_line.steep;
            n_active    = 1'b1;
        end else if (emit) begin
            if (last) begin
                n_active = 1'b0;
            end else begin
                if (move_minor) begin
                    n_err = r_err + t_err'({2'b00, r_minor, 1'b0})
                                  - t_err'({2'b00, r_major, 1'b0});
                end else begin
                    n_err = r_err + t_err'({2'b00, r_minor, 1'b0});
                end
                n_cur_x = r_steep ? minor_next : major_x_next;
                n_cur_y = r_steep ? major_y_next : minor_next;
                n_steps = r_steps - 1'b1;
            end
        end

        n_out = r_out;
        if (emit) begin
            n_out.pixel_x     = r_cur_x;
            n_out.pixel_y     = r_cur_y;
            n_out.pixel_color = i_color;
            n_out.last_pixel  = last;
        end
        n_out_valid = o_out_free ? emit : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_err       <= '0;
            r_steps     <= '0;
            r_major     <= '0;
            r_minor     <= '0;
            r_minor_dec <= 1'b0;
            r_steep     <= 1'b0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_err       <= n_err;
            r_steps     <= n_steps;
            r_major     <= n_major;
            r_minor     <= n_minor;
            r_minor_dec <= n_minor_dec;
            r_steep     <= n_steep;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `LRS_ASSERT_NEXT(a_last_ends_line, i_clk, i_rst_n, emit && last, !r_active)
    `LRS_ASSERT_NEXT(a_load_arms_line, i_clk, i_rst_n, load,
                     r_active && (r_steps == r_major))
    `LRS_ASSERT_SAME(a_steps_bounded, i_clk, i_rst_n, r_active, r_steps <= r_major)
    `LRS_ASSERT_NEXT(a_idle_step_silent, i_clk, i_rst_n,
                     proc && (i_kind == KindStep) && !r_active, !r_out_valid)

endmodule

// ===== src/line_raster_stepper.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid/o_in_stall    t_in_item (load or step)
// out       output     o_out_valid/i_out_stall  t_out_item (one pixel)
// cfg       input      i_cfg_valid/o_cfg_ready  draw color, 4 bits
//
// One item per cycle while the output does not stall: an item is taken into the
// input register, then its setup or step logic writes the state and the output
// register, which presents the pixel of a step item.
// Synchronous active-low reset clears the line state (idle), both valid flags
// and sets the draw color to 15.
// A stalled output holds its pixel; the input stalls only once the item in the
// input register cannot move on.

module line_raster_stepper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lrs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lrs_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  lrs_pkg::t_color    i_cfg_data
);
    import lrs_pkg::*;

    logic     r_in_valid;
    t_in_item r_in;
    t_color   r_color;
    t_line    line;
    logic     out_free;

    assign o_in_stall  = r_in_valid && !out_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= DrawColorReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_color <= i_cfg_data;
        end
    end

    lrs_setup u_setup (
        .i_item (r_in),
        .o_line (line)
    );

    lrs_stepper u_stepper (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_proc_valid (r_in_valid),
        .i_kind       (r_in.kind),
        .i_line       (line),
        .i_color      (r_color),
        .i_out_stall  (i_out_stall),
        .o_out_free   (out_free),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item)
    );

endmodule
